@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion macros shared by the rise-check RTL.

// Property checked on every rising edge, off while reset is low.
`define SRPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/srpc_pkg.sv @@
// Shared constants and pipeline payload types for the rise-possibility check.
`timescale 1ns / 1ps

package srpc_pkg;

  // Cosine series length, constant term included.
  localparam int ITERATIONS   = 16;
  localparam int TERMS        = ITERATIONS - 1;
  // Register stages through the cosine-cube unit.
  localparam int COS_LAT      = 3 * ITERATIONS + 2;
  localparam int BISECT_STEPS = 17;

  localparam logic [30:0] DEG_TO_RAD_K     = 31'd1228166280;
  localparam logic [47:0] QCUBE_K          = 48'd262793200000000;
  localparam logic [16:0] RIGHT_ANGLE_MDEG = 17'd90000;
  localparam logic [17:0] HALF_TURN_MDEG   = 18'd180000;
  localparam logic [16:0] THETA_HI_INIT    = 17'd90001;
  localparam logic [30:0] Q30_ONE          = 31'h4000_0000;

  localparam logic [12:0] RADIUS_RESET     = 13'd6378;
  localparam logic [16:0] MIN_ELEV_RESET   = 17'd10000;

  typedef enum logic {
    CFG_EARTH_RADIUS  = 1'b0,
    CFG_MIN_ELEVATION = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [16:0] el;     // clamped elevation floor
    logic [16:0] track;  // highest ground-track latitude
    logic [17:0] alat;   // absolute observer latitude
  } geo_t;

  typedef struct packed {
    logic        rej;
    geo_t        geo;
    logic [30:0] c3;
    logic [16:0] lo;
    logic [16:0] hi;
  } step_t;

endpackage

@@ design/srpc_cos_cube.sv @@
// Pipelined cube of the series cosine of an angle in millidegrees, Q30.
`timescale 1ns / 1ps

module srpc_cos_cube (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] mdeg,
  output logic [30:0] cube
);
  import srpc_pkg::*;

  localparam logic signed [33:0] SUM_INIT = 34'sd1073741824;

  logic [47:0] x_full;
  logic [30:0] x_r;
  logic [61:0] x2_full;
  logic [31:0] x2_0_r;

  logic [31:0]        ap_r   [1:TERMS];
  logic [31:0]        x2a_r  [1:TERMS];
  logic signed [33:0] suma_r [1:TERMS];
  logic [31:0]        bq_r   [1:TERMS];
  logic [31:0]        bp_r   [1:TERMS];
  logic [31:0]        x2b_r  [1:TERMS];
  logic signed [33:0] sumb_r [1:TERMS];
  logic [31:0]        term_r [1:TERMS];
  logic [31:0]        x2_r   [1:TERMS];
  logic signed [33:0] sum_r  [1:TERMS];

  logic signed [33:0] s_fin;
  logic [30:0] v_nxt, v_r, v2_r, sq_r, cube_r;
  logic [61:0] sq_full, cb_full;

  assign x_full  = 48'(mdeg) * 48'(DEG_TO_RAD_K);
  assign x2_full = 62'(x_r) * 62'(x_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_full[46:16];
      x2_0_r <= x2_full[61:30];
    end
  end

  // Each series term: multiply by x^2, then divide by (2k-1)(2k) through a
  // reciprocal product and one correction step.
  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    localparam int D  = (2 * k - 1) * (2 * k);
    localparam int SH = 30 + $clog2(D + 1);
    localparam logic [31:0] M = 32'((64'd1 << SH) / D);

    logic [31:0]        t_src, x_src;
    logic signed [33:0] s_src;
    logic [63:0]        a_full, b_full;
    logic [43:0]        qd, rem;
    logic [31:0]        tnext;

    if (k == 1) begin : g_first
      assign t_src = 32'(Q30_ONE);
      assign x_src = x2_0_r;
      assign s_src = SUM_INIT;
    end else begin : g_rest
      assign t_src = term_r[k-1];
      assign x_src = x2_r[k-1];
      assign s_src = sum_r[k-1];
    end

    assign a_full = 64'(t_src) * 64'(x_src);
    assign b_full = 64'(ap_r[k]) * 64'(M);
    assign qd     = 44'(bq_r[k]) * 44'(D);
    assign rem    = 44'(bp_r[k]) - qd;
    assign tnext  = (rem >= 44'(D)) ? bq_r[k] + 32'd1 : bq_r[k];

    always_ff @(posedge clk) begin
      if (en) begin
        ap_r[k]   <= a_full[61:30];
        x2a_r[k]  <= x_src;
        suma_r[k] <= s_src;
        bq_r[k]   <= 32'(b_full >> SH);
        bp_r[k]   <= ap_r[k];
        x2b_r[k]  <= x2a_r[k];
        sumb_r[k] <= suma_r[k];
        term_r[k] <= tnext;
        x2_r[k]   <= x2b_r[k];
        if (k % 2 == 1) begin
          sum_r[k] <= sumb_r[k] - $signed({2'b00, tnext});
        end else begin
          sum_r[k] <= sumb_r[k] + $signed({2'b00, tnext});
        end
      end
    end
  end

  // Clamp the series to [0, 1], then cube.
  assign s_fin = sum_r[TERMS];
  always_comb begin
    if (s_fin < 0) begin
      v_nxt = '0;
    end else if (s_fin > SUM_INIT) begin
      v_nxt = Q30_ONE;
    end else begin
      v_nxt = s_fin[30:0];
    end
  end

  assign sq_full = 62'(v_r) * 62'(v_r);
  assign cb_full = 62'(sq_r) * 62'(v2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      sq_r   <= sq_full[60:30];
      v2_r   <= v_r;
      cube_r <= cb_full[60:30];
    end
  end

  assign cube = cube_r;

endmodule

@@ design/srpc_bisect_step.sv @@
// One bisection step of the arc-cosine search, with its own cosine pipeline.
`timescale 1ns / 1ps

module srpc_bisect_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  srpc_pkg::step_t s_in,
  output logic            out_valid,
  output srpc_pkg::step_t s_out
);
  import srpc_pkg::*;

  function automatic logic [16:0] midpoint(input logic [16:0] lo, input logic [16:0] hi);
    logic [17:0] s;
    s = 18'(lo) + 18'(hi);
    return s[17:1];
  endfunction

  logic [16:0]        mid_in, mid_d;
  logic [30:0]        cube;
  step_t              dly_r [0:COS_LAT-1];
  logic [COS_LAT-1:0] vld_r;
  step_t              d, s_nxt, s_r;
  logic               active, pass, v_r;

  assign mid_in = midpoint(s_in.lo, s_in.hi);

  srpc_cos_cube u_cos (
    .clk  (clk),
    .en   (en),
    .mdeg (mid_in),
    .cube (cube)
  );

  // Hold the request beside the cosine pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[COS_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= s_in;
      for (int i = 1; i < COS_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign d      = dly_r[COS_LAT-1];
  assign mid_d  = midpoint(d.lo, d.hi);
  assign active = (d.hi - d.lo) > 17'd1;
  assign pass   = cube >= d.c3;

  always_comb begin
    s_nxt = d;
    if (active) begin
      if (pass) begin
        s_nxt.lo = mid_d;
      end else begin
        s_nxt.hi = mid_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vld_r[COS_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign out_valid = v_r;
  assign s_out     = s_r;

endmodule

@@ design/satellite_rise_possibility_check_unit.sv @@
// Top level of the satellite rise-possibility screen.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Screens one orbiting object per request: from inclination, mean motion and
// observer latitude it reports whether the object can ever clear the elevation
// floor, and the reach (track latitude plus coverage half-angle). The datapath
// is a single linear pipeline and takes a new request every clock unless
// stalled; most of its depth lies in the eighteen cosine-cube units in
// series (one for the elevation floor, one per bisection step, each
// 3*ITERATIONS + 2 deep). The pipeline stalls as a whole only when a
// finished result waits at the output and the last stage holds another one.
// Configuration writes take effect at once and must be made while idle.
module satellite_rise_possibility_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [17:0] inclination_mdeg, [38:18] mean_motion, [56:39] observer_lat_mdeg
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] could_rise, [18:1] reach_mdeg
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata
);
  import srpc_pkg::*;

  typedef struct packed {
    logic        rej;
    geo_t        geo;
    logic [29:0] q3;
  } pre_t;

  // ---------------- configuration registers ----------------
  logic [12:0] radius_r;
  logic [16:0] el_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      el_cfg_r <= MIN_ELEV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_EARTH_RADIUS:  radius_r <= cfg_wdata[12:0];
        CFG_MIN_ELEVATION: el_cfg_r <= cfg_wdata;
      endcase
    end
  end

  // ---------------- pipeline advance ----------------
  // Advance whenever the output register can take a result, or when the last
  // stage is empty so that shifting loses nothing.
  logic        adv;
  step_t       st [0:BISECT_STEPS];
  logic        vs [0:BISECT_STEPS];
  logic        out_valid_r, out_could_r;
  logic [17:0] out_reach_r;

  assign adv       = out_tready || !out_valid_r || !vs[BISECT_STEPS];
  assign in_tready = adv;

  // ---------------- input stage: unpack, fold, clamp ----------------
  logic [17:0]        incl, incl_c, alat;
  logic [20:0]        n_in;
  logic signed [17:0] lat;
  geo_t               geo_in;

  assign incl = in_tdata[17:0];
  assign n_in = in_tdata[38:18];
  assign lat  = $signed(in_tdata[56:39]);

  always_comb begin
    incl_c = (incl > HALF_TURN_MDEG) ? HALF_TURN_MDEG : incl;
    // Fold retrograde orbits to their prograde equivalent track.
    geo_in.track = (incl_c > 18'(RIGHT_ANGLE_MDEG)) ? 17'(HALF_TURN_MDEG - incl_c)
                                                   : incl_c[16:0];
    alat         = lat[17] ? (~in_tdata[56:39] + 18'd1) : in_tdata[56:39];
    geo_in.alat  = alat;
    geo_in.el    = (el_cfg_r > RIGHT_ANGLE_MDEG) ? RIGHT_ANGLE_MDEG : el_cfg_r;
  end

  logic        vi_r;
  logic [20:0] i_n_r;
  logic [12:0] i_rad_r;
  geo_t        i_geo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r <= 1'b0;
    end else if (adv) begin
      vi_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_n_r   <= n_in;
      i_rad_r <= radius_r;
      i_geo_r <= geo_in;
    end
  end

  // ---------------- q^3 = n^2 R^3 K / 2^96 ----------------
  // Seven stages: squares, cube, split product, sum, six partial products of
  // the constant, two levels of addition.
  logic        va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r;
  logic [41:0] a_n2_r, b_n2_r;
  logic [25:0] a_r2_r;
  logic [12:0] a_rad_r;
  logic        a_nz_r, b_nz_r, c_nz_r;
  logic [38:0] b_r3_r;
  logic [59:0] c_pl_r, c_ph_r;
  logic [80:0] p_full;
  logic [78:0] d_p_r;
  logic        d_rej_r, e_rej_r, f_rej_r, g_rej_r;
  logic [26:0] limb [0:2];
  logic [50:0] e_lo_r [0:2];
  logic [50:0] e_hi_r [0:2];
  logic [75:0] f_t_r [0:2];
  logic [128:0] g_s_r;
  geo_t        a_geo_r, b_geo_r, c_geo_r, d_geo_r, e_geo_r, f_geo_r, g_geo_r;

  assign p_full  = (81'(c_ph_r) << 21) + 81'(c_pl_r);
  assign limb[0] = d_p_r[26:0];
  assign limb[1] = {1'b0, d_p_r[52:27]};
  assign limb[2] = {1'b0, d_p_r[78:53]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else if (adv) begin
      va_r <= vi_r;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_n2_r  <= 42'(i_n_r) * 42'(i_n_r);
      a_r2_r  <= 26'(i_rad_r) * 26'(i_rad_r);
      a_rad_r <= i_rad_r;
      a_nz_r  <= (i_n_r == 21'd0);
      a_geo_r <= i_geo_r;

      b_r3_r  <= 39'(a_r2_r) * 39'(a_rad_r);
      b_n2_r  <= a_n2_r;
      b_nz_r  <= a_nz_r;
      b_geo_r <= a_geo_r;

      c_pl_r  <= 60'(b_n2_r[20:0]) * 60'(b_r3_r);
      c_ph_r  <= 60'(b_n2_r[41:21]) * 60'(b_r3_r);
      c_nz_r  <= b_nz_r;
      c_geo_r <= b_geo_r;

      // Drop zero rates and products at or above 2^79 (q beyond one).
      d_p_r   <= p_full[78:0];
      d_rej_r <= c_nz_r || (p_full[80:79] != 2'b00);
      d_geo_r <= c_geo_r;

      for (int i = 0; i < 3; i++) begin
        e_lo_r[i] <= 51'(limb[i]) * 51'(QCUBE_K[23:0]);
        e_hi_r[i] <= 51'(limb[i]) * 51'(QCUBE_K[47:24]);
      end
      e_rej_r <= d_rej_r;
      e_geo_r <= d_geo_r;

      for (int i = 0; i < 3; i++) begin
        f_t_r[i] <= 76'(e_lo_r[i]) + (76'(e_hi_r[i]) << 24);
      end
      f_rej_r <= e_rej_r;
      f_geo_r <= e_geo_r;

      g_s_r   <= 129'(f_t_r[0]) + (129'(f_t_r[1]) << 27) + (129'(f_t_r[2]) << 53);
      g_rej_r <= f_rej_r;
      g_geo_r <= f_geo_r;
    end
  end

  // ---------------- cos(el)^3 beside a delay of the request ----------------
  pre_t               pre_in, pre_d;
  pre_t               pre_dly_r [0:COS_LAT-1];
  logic [COS_LAT-1:0] pre_vld_r;
  logic [30:0]        el_cube;

  // Reject when q^3 reaches one: the orbit does not clear the surface.
  assign pre_in.rej = g_rej_r || (g_s_r[128:126] != 3'b000);
  assign pre_in.geo = g_geo_r;
  assign pre_in.q3  = g_s_r[125:96];

  srpc_cos_cube u_cos_el (
    .clk  (clk),
    .en   (adv),
    .mdeg (g_geo_r.el),
    .cube (el_cube)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= '0;
    end else if (adv) begin
      pre_vld_r <= {pre_vld_r[COS_LAT-2:0], vg_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_dly_r[0] <= pre_in;
      for (int i = 1; i < COS_LAT; i++) begin
        pre_dly_r[i] <= pre_dly_r[i-1];
      end
    end
  end

  assign pre_d = pre_dly_r[COS_LAT-1];

  // ---------------- target c3 = q^3 cos(el)^3, open the search bracket ------
  logic [60:0] c3_full;
  step_t       c3_step_r;
  logic        c3_v_r;

  assign c3_full = 61'(pre_d.q3) * 61'(el_cube);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_v_r <= 1'b0;
    end else if (adv) begin
      c3_v_r <= pre_vld_r[COS_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_step_r.rej <= pre_d.rej;
      c3_step_r.geo <= pre_d.geo;
      c3_step_r.c3  <= c3_full[60:30];
      c3_step_r.lo  <= '0;
      c3_step_r.hi  <= THETA_HI_INIT;
    end
  end

  assign st[0] = c3_step_r;
  assign vs[0] = c3_v_r;

  // ---------------- arc-cosine by bisection, one unit per step ----------------
  for (genvar s = 0; s < BISECT_STEPS; s++) begin : g_step
    srpc_bisect_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (vs[s]),
      .s_in      (st[s]),
      .out_valid (vs[s+1]),
      .s_out     (st[s+1])
    );
  end

  // ---------------- half-angle, reach and decision ----------------
  step_t       fin;
  logic [16:0] lam;
  logic [17:0] reach;
  logic        could;

  assign fin   = st[BISECT_STEPS];
  assign lam   = (fin.lo > fin.geo.el) ? fin.lo - fin.geo.el : '0;
  assign reach = 18'(fin.geo.track) + 18'(lam);
  assign could = (fin.geo.alat <= reach);

  // Output register: load when empty or when the held result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      out_valid_r <= vs[BISECT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_could_r <= fin.rej ? 1'b0 : could;
      out_reach_r <= fin.rej ? 18'd0 : reach;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_reach_r, out_could_r};

  // ---------------- assertions ----------------
  // A blocked output with a full last stage must freeze the pipeline.
  `SRPC_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_r && !out_tready && vs[BISECT_STEPS], $stable(st[BISECT_STEPS]), "pipeline moved while output was blocked")
  // After all steps the bracket is exactly one millidegree wide.
  `SRPC_ASSERT(a_bracket_closed, clk, rst_n, vs[BISECT_STEPS] |-> (st[BISECT_STEPS].hi == st[BISECT_STEPS].lo + 17'd1), "bisection bracket not closed")

endmodule
